/* rtl/core/rsel_pkg.sv */
`default_nettype none
package rsel_pkg;

    localparam int unsigned GF_W  = 16;
    localparam int unsigned CNT_W = 6;
    localparam int unsigned DEG_W = 6;

    typedef enum logic [0:0] {
        CFG_SYNDROME_COUNT = 1'b0,
        CFG_FIELD_POLY_LOW = 1'b1
    } cfg_index_t;

    localparam logic [CNT_W-1:0] SYNDROME_COUNT_RESET = CNT_W'(32);
    localparam logic [GF_W-1:0]  FIELD_POLY_RESET    = GF_W'(4107);

endpackage
`default_nettype wire

/* rtl/core/rsel_ram.sv */
`default_nettype none
module rsel_ram #(
    parameter int unsigned WIDTH = 16,
    parameter int unsigned DEPTH = 32
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule
`default_nettype wire

/* rtl/core/rsel_gf_mul.sv */
`default_nettype none
module rsel_gf_mul
    import rsel_pkg::*;
(
    input  wire logic [GF_W-1:0] op_a,
    input  wire logic [GF_W-1:0] op_b,
    input  wire logic [GF_W-1:0] poly,
    output logic      [GF_W-1:0] product
);

    // shift and add, reducing the multiplicand each step
    always_comb begin
        logic [GF_W-1:0] a;
        logic [GF_W-1:0] r;
        a = op_a;
        r = '0;
        for (int i = 0; i < GF_W; i++) begin
            if (op_b[i]) begin
                r = r ^ a;
            end
            a = a[GF_W-1] ? ({a[GF_W-2:0], 1'b0} ^ poly) : {a[GF_W-2:0], 1'b0};
        end
        product = r;
    end

endmodule
`default_nettype wire

/* rtl/core/rs_error_locator_solver.sv */
// per syndrome: the discrepancy sums min(L,k) products; if the discrepancy is nonzero,
// a field inverse by 29 squarings/products and then a locator update follow
// after the last syndrome of a codeword, top zero coefficients are trimmed and the rest
// emitted highest first, each held until m_ready; one GF(2^16) multiplier is shared;
// one syndrome at a time; s_ready is low while an item is processed or emitted
// reset: synchronous, active low; locator stores marked invalid by valid bits, no sweep
`default_nettype none
module rs_error_locator_solver
    import rsel_pkg::*;
#(
    parameter int unsigned MAX_SYNDROMES = 32
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire logic [GF_W-1:0]   s_syndrome_value,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output logic      [GF_W-1:0]   m_coefficient,
    output logic      [DEG_W-1:0]  m_locator_degree,
    output logic                   m_is_last,
    input  wire logic              cfg_wr_en,
    input  wire logic [0:0]        cfg_index,
    input  wire logic [GF_W-1:0]   cfg_data
);

    localparam int unsigned LOC = MAX_SYNDROMES + 1;
    localparam int unsigned SW  = $clog2(MAX_SYNDROMES);
    localparam int unsigned KW  = $clog2(LOC);

    typedef enum logic [14:0] {
        ST_IDLE = 15'b000000000000001,
        ST_DRD  = 15'b000000000000010,
        ST_DACC = 15'b000000000000100,
        ST_CHK  = 15'b000000000001000,
        ST_ISQ  = 15'b000000000010000,
        ST_IMX  = 15'b000000000100000,
        ST_SCL  = 15'b000000001000000,
        ST_URD  = 15'b000000010000000,
        ST_UWR  = 15'b000000100000000,
        ST_END  = 15'b000001000000000,
        ST_TRD  = 15'b000010000000000,
        ST_TCHK = 15'b000100000000000,
        ST_ERD  = 15'b001000000000000,
        ST_ELD  = 15'b010000000000000,
        ST_EWT  = 15'b100000000000000
    } state_t;

    state_t state_reg, state_next;

    logic [CNT_W-1:0] cnt_reg;
    logic [GF_W-1:0]  poly_reg;

    logic [SW-1:0]    step_reg, step_next;
    logic [DEG_W-1:0] deg_reg, deg_next;
    logic [KW-1:0]    lus1_reg, lus1_next;
    logic [GF_W-1:0]  bdisc_reg, bdisc_next;
    logic [GF_W-1:0]  delta_reg, delta_next;
    logic [GF_W-1:0]  acc_reg, acc_next;
    logic [GF_W-1:0]  scale_reg, scale_next;
    logic             lenchg_reg, lenchg_next;
    logic [SW-1:0]    i_reg, i_next;
    logic [3:0]       icnt_reg, icnt_next;
    logic [KW-1:0]    t_reg, t_next;
    logic [KW-1:0]    last_reg, last_next;
    logic             use_reg, use_next;
    logic             clear_run;

    logic             loc_valid_reg [LOC];
    logic             prev_valid_reg [LOC];
    logic             loc_hit_reg, loc_zero_reg, prev_hit_reg, prev_zero_reg;

    logic             m_valid_reg, m_valid_next;
    logic [GF_W-1:0]  coef_reg, coef_next;
    logic             is_last_reg, is_last_next;

    logic [SW-1:0]    syn_wr_addr, syn_rd_addr;
    logic [GF_W-1:0]  syn_rd_data;
    logic [KW-1:0]    loc_rd_addr, prev_rd_addr;
    logic [GF_W-1:0]  loc_rd_data, prev_rd_data, loc_val, prev_val, new_loc;
    logic             loc_wr_en, prev_wr_en;

    logic [GF_W-1:0]  mul_a, mul_b, mul_p;
    logic [KW-1:0]    n_eff, k_plus1, shift;
    logic [SW-1:0]    imax;
    logic             s_fire;

    assign s_fire = s_valid && s_ready;
    assign s_ready = (state_reg == ST_IDLE);

    always_comb begin
        if (cnt_reg == '0) begin
            n_eff = KW'(1);
        end else if (7'(cnt_reg) > 7'(MAX_SYNDROMES)) begin
            n_eff = KW'(MAX_SYNDROMES);
        end else begin
            n_eff = KW'(cnt_reg);
        end
    end

    assign k_plus1 = KW'(step_reg) + KW'(1);
    assign shift   = k_plus1 - lus1_reg;
    assign imax    = (7'(deg_reg) < 7'(step_reg)) ? SW'(deg_reg) : step_reg;

    assign loc_val  = loc_hit_reg ? loc_rd_data : GF_W'(loc_zero_reg);
    assign prev_val = prev_hit_reg ? prev_rd_data : GF_W'(prev_zero_reg);
    assign new_loc  = use_reg ? (loc_val ^ mul_p) : loc_val;

    always_comb begin
        unique case (state_reg)
            ST_DACC: begin mul_a = loc_val;   mul_b = syn_rd_data; end
            ST_ISQ:  begin mul_a = acc_reg;   mul_b = acc_reg;     end
            ST_IMX:  begin mul_a = acc_reg;   mul_b = bdisc_reg;   end
            ST_SCL:  begin mul_a = delta_reg; mul_b = acc_reg;     end
            default: begin mul_a = scale_reg; mul_b = prev_val;    end
        endcase
    end

    rsel_gf_mul u_mul (
        .op_a    (mul_a),
        .op_b    (mul_b),
        .poly    (poly_reg),
        .product (mul_p)
    );

    // syndrome write address and read addresses
    always_comb begin
        syn_wr_addr  = step_reg;
        syn_rd_addr  = step_reg - i_reg;
        loc_rd_addr  = t_reg;
        prev_rd_addr = t_reg - shift;
        if (state_reg == ST_DRD) begin
            loc_rd_addr = KW'(i_reg);
        end
    end

    assign loc_wr_en  = (state_reg == ST_UWR);
    assign prev_wr_en = (state_reg == ST_UWR) && lenchg_reg;

    rsel_ram #(.WIDTH(GF_W), .DEPTH(MAX_SYNDROMES)) u_syn_ram (
        .aclk    (aclk),
        .wr_en   (s_fire),
        .wr_addr (syn_wr_addr),
        .wr_data (s_syndrome_value),
        .rd_addr (syn_rd_addr),
        .rd_data (syn_rd_data)
    );

    rsel_ram #(.WIDTH(GF_W), .DEPTH(LOC)) u_loc_ram (
        .aclk    (aclk),
        .wr_en   (loc_wr_en),
        .wr_addr (t_reg),
        .wr_data (new_loc),
        .rd_addr (loc_rd_addr),
        .rd_data (loc_rd_data)
    );

    rsel_ram #(.WIDTH(GF_W), .DEPTH(LOC)) u_prev_ram (
        .aclk    (aclk),
        .wr_en   (prev_wr_en),
        .wr_addr (t_reg),
        .wr_data (loc_val),
        .rd_addr (prev_rd_addr),
        .rd_data (prev_rd_data)
    );

    always_comb begin
        state_next   = state_reg;
        step_next    = step_reg;
        deg_next     = deg_reg;
        lus1_next    = lus1_reg;
        bdisc_next   = bdisc_reg;
        delta_next   = delta_reg;
        acc_next     = acc_reg;
        scale_next   = scale_reg;
        lenchg_next  = lenchg_reg;
        i_next       = i_reg;
        icnt_next    = icnt_reg;
        t_next       = t_reg;
        last_next    = last_reg;
        use_next     = use_reg;
        m_valid_next = m_valid_reg;
        coef_next    = coef_reg;
        is_last_next = is_last_reg;
        clear_run    = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_fire) begin
                    delta_next = s_syndrome_value;
                    i_next     = SW'(1);
                    state_next = (imax == '0) ? ST_CHK : ST_DRD;
                end
            end
            ST_DRD: begin
                state_next = ST_DACC;
            end
            ST_DACC: begin
                delta_next = delta_reg ^ mul_p;
                if (i_reg == imax) begin
                    state_next = ST_CHK;
                end else begin
                    i_next     = i_reg + SW'(1);
                    state_next = ST_DRD;
                end
            end
            ST_CHK: begin
                acc_next   = bdisc_reg;
                icnt_next  = '0;
                state_next = (delta_reg == '0) ? ST_END : ST_ISQ;
            end
            ST_ISQ: begin
                acc_next   = mul_p;
                state_next = (icnt_reg == 4'd14) ? ST_SCL : ST_IMX;
            end
            ST_IMX: begin
                acc_next   = mul_p;
                icnt_next  = icnt_reg + 4'd1;
                state_next = ST_ISQ;
            end
            ST_SCL: begin
                scale_next  = mul_p;
                t_next      = KW'(LOC - 1);
                lenchg_next = ({2'b00, deg_reg, 1'b0} <= 9'(step_reg));
                state_next  = ST_URD;
            end
            ST_URD: begin
                use_next   = (t_reg >= shift) && (t_reg <= n_eff);
                state_next = ST_UWR;
            end
            ST_UWR: begin
                if (t_reg == '0) begin
                    if (lenchg_reg) begin
                        deg_next   = DEG_W'(7'(k_plus1) - 7'(deg_reg));
                        bdisc_next = delta_reg;
                        lus1_next  = k_plus1;
                    end
                    state_next = ST_END;
                end else begin
                    t_next     = t_reg - KW'(1);
                    state_next = ST_URD;
                end
            end
            ST_END: begin
                if (k_plus1 < n_eff) begin
                    step_next  = SW'(k_plus1);
                    state_next = ST_IDLE;
                end else begin
                    t_next     = n_eff;
                    state_next = ST_TRD;
                end
            end
            ST_TRD: begin
                state_next = ST_TCHK;
            end
            ST_TCHK: begin
                if ((t_reg != '0) && (loc_val == '0)) begin
                    t_next     = t_reg - KW'(1);
                    state_next = ST_TRD;
                end else begin
                    last_next  = t_reg;
                    state_next = ST_ERD;
                end
            end
            ST_ERD: begin
                state_next = ST_ELD;
            end
            ST_ELD: begin
                coef_next    = loc_val;
                is_last_next = (t_reg == '0);
                m_valid_next = 1'b1;
                state_next   = ST_EWT;
            end
            ST_EWT: begin
                if (m_ready) begin
                    m_valid_next = 1'b0;
                    if (t_reg == '0) begin
                        clear_run  = 1'b1;
                        step_next  = '0;
                        deg_next   = '0;
                        lus1_next  = '0;
                        bdisc_next = GF_W'(1);
                        state_next = ST_IDLE;
                    end else begin
                        t_next     = t_reg - KW'(1);
                        state_next = ST_ERD;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            cnt_reg     <= SYNDROME_COUNT_RESET;
            poly_reg    <= FIELD_POLY_RESET;
            step_reg    <= '0;
            deg_reg     <= '0;
            lus1_reg    <= '0;
            bdisc_reg   <= GF_W'(1);
            m_valid_reg <= 1'b0;
            for (int j = 0; j < LOC; j++) begin
                loc_valid_reg[j]  <= 1'b0;
                prev_valid_reg[j] <= 1'b0;
            end
        end else begin
            state_reg   <= state_next;
            step_reg    <= step_next;
            deg_reg     <= deg_next;
            lus1_reg    <= lus1_next;
            bdisc_reg   <= bdisc_next;
            m_valid_reg <= m_valid_next;
            if (cfg_wr_en) begin
                unique case (cfg_index_t'(cfg_index))
                    CFG_SYNDROME_COUNT: cnt_reg  <= cfg_data[CNT_W-1:0];
                    CFG_FIELD_POLY_LOW: poly_reg <= cfg_data;
                    default: ;
                endcase
            end
            if (clear_run) begin
                for (int j = 0; j < LOC; j++) begin
                    loc_valid_reg[j]  <= 1'b0;
                    prev_valid_reg[j] <= 1'b0;
                end
            end else begin
                if (loc_wr_en) begin
                    loc_valid_reg[t_reg] <= 1'b1;
                end
                if (prev_wr_en) begin
                    prev_valid_reg[t_reg] <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        delta_reg     <= delta_next;
        acc_reg       <= acc_next;
        scale_reg     <= scale_next;
        lenchg_reg    <= lenchg_next;
        i_reg         <= i_next;
        icnt_reg      <= icnt_next;
        t_reg         <= t_next;
        last_reg      <= last_next;
        use_reg       <= use_next;
        coef_reg      <= coef_next;
        is_last_reg   <= is_last_next;
        loc_hit_reg   <= loc_valid_reg[loc_rd_addr];
        loc_zero_reg  <= (loc_rd_addr == '0);
        prev_hit_reg  <= prev_valid_reg[prev_rd_addr];
        prev_zero_reg <= (prev_rd_addr == '0);
    end

    assign m_valid          = m_valid_reg;
    assign m_coefficient    = coef_reg;
    assign m_locator_degree = DEG_W'(last_reg);
    assign m_is_last        = is_last_reg;

    a_ready_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> !m_valid)
        else $error("input ready while a result is pending");

    a_step_range: assert property (@(posedge aclk) disable iff (!aresetn)
        32'(step_reg) < MAX_SYNDROMES)
        else $error("step index out of range");

    a_last_ends: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && m_is_last) |=> s_ready)
        else $error("run did not end after last coefficient");

    a_deg_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        32'(deg_reg) <= MAX_SYNDROMES)
        else $error("locator degree out of range");

endmodule
`default_nettype wire
